>>> hw/rtl/ddcm_pkg.sv
// Shared types and constants for the dual deque card mover.
// No dependencies; every other file of the block imports this package.
`default_nettype none
package ddcm_pkg;

	// Default sizes, handed to the top-level parameters
	localparam int STORE_DEPTH_DEF = 64;
	localparam int MAX_DECK_DEF    = 31;

	// Fixed field widths
	localparam int FUNC_W = 2;
	localparam int CMD_W  = 4;
	localparam int CFG_W  = 5;
	localparam int VAL_W  = 7;

	// Request function codes
	typedef enum logic [FUNC_W-1:0] {
		FUNC_RESTART = 2'd0,
		FUNC_MOVE    = 2'd1,
		FUNC_DUMP    = 2'd2,
		FUNC_NOP     = 2'd3
	} ddcm_func_t;

	// Controller to datapath commands
	typedef struct packed {
		logic accept;      // latch the request payload
		logic rst_start;   // load counts and pointers for a restart
		logic rst_write;   // write one card slot into both decks
		logic mv_take;     // read and remove the source card
		logic mv_put;      // write the card at the destination
		logic dump_count;  // emit the count, start reading cards
		logic dump_card;   // emit one card
	} ddcm_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic rst_empty;   // restart with zero cards
		logic rst_last;    // current slot is the final one
		logic mv_ok;       // latched move has an effect
		logic dump_empty;  // deck being dumped holds no card
		logic dump_last;   // current card is the bottom one
		logic out_free;    // output register can take a result
	} ddcm_sts_t;

endpackage
`default_nettype wire

>>> hw/rtl/ddcm_in_if.sv
// Request channel of the card mover: valid/ready handshake and request fields.
// Depends on ddcm_pkg for the field widths.
`default_nettype none
interface ddcm_in_if import ddcm_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [FUNC_W-1:0]  func;
	logic [CMD_W-1:0]   command;
	logic               dump_side;

	modport source (output valid, output func, output command, output dump_side, input ready);
	modport sink   (input valid, input func, input command, input dump_side, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/ddcm_out_if.sv
// Result channel of the card mover: valid/ready handshake and result fields.
// Depends on ddcm_pkg for the field widths.
`default_nettype none
interface ddcm_out_if import ddcm_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     is_card;
	logic signed [VAL_W-1:0]  value;
	logic                     last;

	modport source (output valid, output is_card, output value, output last, input ready);
	modport sink   (input valid, input is_card, input value, input last, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/ddcm_ctrl.sv
// Sequencing state machine of the card mover: restart fill, two-step move, dump walk.
// Depends on ddcm_pkg for the command/status structs and function codes.
`default_nettype none
module ddcm_ctrl import ddcm_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               item_valid,
	input  wire logic [FUNC_W-1:0]  item_func,
	output logic                    item_ready,
	input  wire ddcm_sts_t          sts,
	output ddcm_cmd_t               cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_RESTART,
		S_MV_TAKE,
		S_MV_PUT,
		S_D_COUNT,
		S_D_CARD
	} state_t;

	state_t state_q;
	state_t state_d;

	// Next state and commands
	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		item_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.accept = 1'b1;
					case (ddcm_func_t'(item_func))
						FUNC_RESTART: begin
							cmd.rst_start = 1'b1;
							state_d       = S_RESTART;
						end
						FUNC_MOVE: state_d = S_MV_TAKE;
						FUNC_DUMP: state_d = S_D_COUNT;
						default:   state_d = S_IDLE;
					endcase
				end
			end
			S_RESTART: begin
				if (sts.rst_empty) begin
					state_d = S_IDLE;
				end else begin
					cmd.rst_write = 1'b1;
					if (sts.rst_last) state_d = S_IDLE;
				end
			end
			S_MV_TAKE: begin
				if (sts.mv_ok) begin
					cmd.mv_take = 1'b1;
					state_d     = S_MV_PUT;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_MV_PUT: begin
				cmd.mv_put = 1'b1;
				state_d    = S_IDLE;
			end
			S_D_COUNT: begin
				if (sts.out_free) begin
					cmd.dump_count = 1'b1;
					state_d        = sts.dump_empty ? S_IDLE : S_D_CARD;
				end
			end
			S_D_CARD: begin
				if (sts.out_free) begin
					cmd.dump_card = 1'b1;
					if (sts.dump_last) state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/ddcm_dp.sv
// Datapath of the card mover: deck memories, top pointers, counts, config and result register.
// Depends on ddcm_pkg; driven by ddcm_ctrl through the command/status structs.
`default_nettype none
module ddcm_dp import ddcm_pkg::*; #(
	parameter int STORE_DEPTH = STORE_DEPTH_DEF,
	parameter int MAX_DECK    = MAX_DECK_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_wr_en,
	input  wire logic [CFG_W-1:0]   cfg_wr_data,
	input  wire logic [CMD_W-1:0]   item_command,
	input  wire logic               item_dump_side,
	input  wire ddcm_cmd_t          cmd,
	output ddcm_sts_t               sts,
	input  wire logic               out_ready,
	output logic                    out_valid,
	output logic                    out_is_card,
	output logic signed [VAL_W-1:0] out_value,
	output logic                    out_last
);

	localparam int AW  = $clog2(STORE_DEPTH);
	localparam int CW  = $clog2(STORE_DEPTH + 1);
	localparam int LIM = (MAX_DECK < STORE_DEPTH) ? MAX_DECK : STORE_DEPTH;

	// (base + off) mod depth, both operands below the depth (off may equal it)
	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
	                                           input logic [CW-1:0] off);
		logic [AW:0] s;
		s = (AW+1)'(base) + (AW+1)'(off);
		if (s >= (AW+1)'(STORE_DEPTH)) s = s - (AW+1)'(STORE_DEPTH);
		return s[AW-1:0];
	endfunction

	// Deck storage
	logic [VAL_W-1:0] left_mem  [STORE_DEPTH];
	logic [VAL_W-1:0] right_mem [STORE_DEPTH];

	logic [CFG_W-1:0] deck_size_q;
	logic [AW-1:0]    top_l_q, top_r_q;
	logic [CW-1:0]    cnt_l_q, cnt_r_q;
	logic [CMD_W-1:0] command_q;
	logic             side_q;
	logic [CW-1:0]    n_q;
	logic [CW-1:0]    idx_q;
	logic [CW-1:0]    k_q;
	logic [AW-1:0]    ptr_q;
	logic [VAL_W-1:0] rd_l_q, rd_r_q;

	logic             sd, se, dd, de;
	logic [AW-1:0]    src_top, dst_top, side_top;
	logic [CW-1:0]    src_cnt, dst_cnt, side_cnt;
	logic [AW-1:0]    take_addr, put_addr;
	logic [CFG_W-1:0] n_clamp;
	logic             rd_en;
	logic [AW-1:0]    rd_addr;
	logic             wr_l_en, wr_r_en;
	logic [AW-1:0]    wr_addr;
	logic [VAL_W-1:0] wr_l_data, wr_r_data;
	logic [VAL_W-1:0] rst_val, src_card, side_card;
	logic             out_free;

	assign sd = command_q[3];
	assign se = command_q[2];
	assign dd = command_q[1];
	assign de = command_q[0];

	// Per-deck selection
	assign src_top  = sd     ? top_r_q : top_l_q;
	assign src_cnt  = sd     ? cnt_r_q : cnt_l_q;
	assign dst_top  = dd     ? top_r_q : top_l_q;
	assign dst_cnt  = dd     ? cnt_r_q : cnt_l_q;
	assign side_top = side_q ? top_r_q : top_l_q;
	assign side_cnt = side_q ? cnt_r_q : cnt_l_q;

	// Move addresses: bottom is top + count - 1 (take) or top + count (put)
	assign take_addr = se ? wrap_add(src_top, src_cnt - CW'(1)) : src_top;
	assign put_addr  = de ? wrap_add(dst_top, dst_cnt) : wrap_add(dst_top, CW'(STORE_DEPTH - 1));

	assign n_clamp  = (deck_size_q > CFG_W'(LIM)) ? CFG_W'(LIM) : deck_size_q;
	assign out_free = !out_valid || out_ready;

	// Status
	always_comb begin
		sts            = '0;
		sts.rst_empty  = (n_q == '0);
		sts.rst_last   = ((idx_q + CW'(1)) == n_q);
		sts.mv_ok      = (command_q[3:2] != command_q[1:0]) && (src_cnt != '0) &&
		                 !((sd != dd) && (dst_cnt == CW'(STORE_DEPTH)));
		sts.dump_empty = (side_cnt == '0);
		sts.dump_last  = (k_q == side_cnt);
		sts.out_free   = out_free;
	end

	// Memory read port, shared by moves and dumps
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = take_addr;
		if (cmd.mv_take) begin
			rd_en = 1'b1;
		end else if (cmd.dump_count) begin
			rd_en   = 1'b1;
			rd_addr = side_top;
		end else if (cmd.dump_card && !sts.dump_last) begin
			rd_en   = 1'b1;
			rd_addr = ptr_q;
		end
	end

	assign src_card  = sd     ? rd_r_q : rd_l_q;
	assign side_card = side_q ? rd_r_q : rd_l_q;
	assign rst_val   = VAL_W'(idx_q) + VAL_W'(1);

	// Memory write port: restart fills both decks, a move writes one
	always_comb begin
		wr_l_en   = 1'b0;
		wr_r_en   = 1'b0;
		wr_addr   = put_addr;
		wr_l_data = src_card;
		wr_r_data = src_card;
		if (cmd.rst_write) begin
			wr_l_en   = 1'b1;
			wr_r_en   = 1'b1;
			wr_addr   = idx_q[AW-1:0];
			wr_l_data = rst_val;
			wr_r_data = VAL_W'(0) - rst_val;
		end else if (cmd.mv_put) begin
			wr_l_en = !dd;
			wr_r_en = dd;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_l_en) left_mem[wr_addr]  <= wr_l_data;
		if (wr_r_en) right_mem[wr_addr] <= wr_r_data;
		if (rd_en) begin
			rd_l_q <= left_mem[rd_addr];
			rd_r_q <= right_mem[rd_addr];
		end
	end

	// Config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deck_size_q <= '0;
		end else if (cfg_wr_en) begin
			deck_size_q <= cfg_wr_data;
		end
	end

	// Request latch and work counters
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			command_q <= item_command;
			side_q    <= item_dump_side;
		end
		if (cmd.rst_start) begin
			n_q   <= CW'(n_clamp);
			idx_q <= '0;
		end
		if (cmd.rst_write) idx_q <= idx_q + CW'(1);
		if (cmd.dump_count) begin
			k_q   <= CW'(1);
			ptr_q <= wrap_add(side_top, CW'(1));
		end
		if (cmd.dump_card) begin
			k_q   <= k_q + CW'(1);
			ptr_q <= wrap_add(ptr_q, CW'(1));
		end
	end

	// Deck pointers and counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_l_q <= '0;
			top_r_q <= '0;
			cnt_l_q <= '0;
			cnt_r_q <= '0;
		end else begin
			if (cmd.rst_start) begin
				top_l_q <= '0;
				top_r_q <= '0;
				cnt_l_q <= CW'(n_clamp);
				cnt_r_q <= CW'(n_clamp);
			end
			if (cmd.mv_take) begin
				if (sd) begin
					cnt_r_q <= cnt_r_q - CW'(1);
					if (!se) top_r_q <= wrap_add(top_r_q, CW'(1));
				end else begin
					cnt_l_q <= cnt_l_q - CW'(1);
					if (!se) top_l_q <= wrap_add(top_l_q, CW'(1));
				end
			end
			if (cmd.mv_put) begin
				if (dd) begin
					cnt_r_q <= cnt_r_q + CW'(1);
					if (!de) top_r_q <= put_addr;
				end else begin
					cnt_l_q <= cnt_l_q + CW'(1);
					if (!de) top_l_q <= put_addr;
				end
			end
			if ((cmd.dump_count && sts.dump_empty) || (cmd.dump_card && sts.dump_last)) begin
				if (side_q) begin
					top_r_q <= '0;
					cnt_r_q <= '0;
				end else begin
					top_l_q <= '0;
					cnt_l_q <= '0;
				end
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.dump_count || cmd.dump_card) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.dump_count) begin
			out_is_card <= 1'b0;
			out_value   <= $signed(VAL_W'(side_cnt));
			out_last    <= sts.dump_empty;
		end else if (cmd.dump_card) begin
			out_is_card <= 1'b1;
			out_value   <= $signed(side_card);
			out_last    <= sts.dump_last;
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/dual_deque_card_mover.sv
// Dual deque card mover: left and right decks kept as double-ended queues.
// Restart: accept, then n slots of both decks written, one per cycle (none when n is 0);
// move: accept, source memory read, destination write; an ignored move does neither;
// dump: count, then n cards, one per cycle while the consumer is ready (shared read port);
// one request at a time. A no-operation request is accepted and does nothing.
// arst_n clears the FSM, counts, pointers and deck size; deck memories are not cleared.
`default_nettype none
module dual_deque_card_mover import ddcm_pkg::*; #(
	parameter int STORE_DEPTH = STORE_DEPTH_DEF,
	parameter int MAX_DECK    = MAX_DECK_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_wr_en,
	input  wire logic [CFG_W-1:0]  cfg_wr_data,
	ddcm_in_if.sink                items,
	ddcm_out_if.source             results
);

	ddcm_cmd_t cmd;
	ddcm_sts_t sts;

	ddcm_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (items.valid),
		.item_func  (items.func),
		.item_ready (items.ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	ddcm_dp #(
		.STORE_DEPTH (STORE_DEPTH),
		.MAX_DECK    (MAX_DECK)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.item_command   (items.command),
		.item_dump_side (items.dump_side),
		.cmd            (cmd),
		.sts            (sts),
		.out_ready      (results.ready),
		.out_valid      (results.valid),
		.out_is_card    (results.is_card),
		.out_value      (results.value),
		.out_last       (results.last)
	);

	// At most one datapath action per cycle
	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.accept, cmd.rst_write, cmd.mv_take, cmd.mv_put,
		          cmd.dump_count, cmd.dump_card}))
		else $error("overlapping datapath commands");

	// A put always follows its take
	a_put_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mv_put |-> $past(cmd.mv_take))
		else $error("move put without a take");

	// No new request while a nonempty dump is walking its cards
	a_dump_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.dump_count && !sts.dump_empty) |=> !items.ready)
		else $error("request taken during dump");

	// A result is only loaded when the output register has room
	a_out_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.dump_count || cmd.dump_card) |-> (!results.valid || results.ready))
		else $error("result register overwritten");

endmodule
`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// Testbench for dual_deque_card_mover: feeds requests with random gaps and stalls,
// predicts every result from its own copy of the two decks and checks them in order.
// Depends on ddcm_pkg and the ddcm_in_if / ddcm_out_if interfaces.
module tb_top;
	import ddcm_pkg::*;

	localparam int CLK_HALF      = 5;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES   = 400;
	localparam int TIMEOUT_NS    = 10_000_000;
	localparam int DEPTH         = STORE_DEPTH_DEF;

	// Deck selectors and the move codes used by name
	localparam logic SIDE_LEFT  = 1'b0;
	localparam logic SIDE_RIGHT = 1'b1;
	localparam logic [CMD_W-1:0] CMD_RB_TO_LT = 4'b1100;  // right bottom -> left top
	localparam logic [CMD_W-1:0] CMD_LT_TO_RB = 4'b0011;  // left top -> right bottom

	typedef struct packed {
		logic                    is_card;
		logic signed [VAL_W-1:0] value;
		logic                    last;
	} deck_result_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_wr_en;
	logic [CFG_W-1:0]  cfg_wr_data;

	ddcm_in_if  items_if ();
	ddcm_out_if results_if ();

	dual_deque_card_mover u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.items       (items_if),
		.results     (results_if)
	);

	// Predicted deck contents and the results still owed by the block
	logic [VAL_W-1:0] deck_mem [2][DEPTH];
	int unsigned      deck_top [2];
	int unsigned      deck_cnt [2];
	logic [CFG_W-1:0] deck_size_q;
	deck_result_t     pending_results [$];

	int send_idle_pct;
	int recv_idle_pct;
	int fail_count;
	int active_count;
	bit hold_req;
	logic hold_on;

	// Clock
	initial clk = 1'b0;
	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// Apply one request to the predicted decks; returns 1 if it had any effect
	function automatic bit predict_request(ddcm_func_t f, logic [CMD_W-1:0] cmd, logic side);
		int i;
		int unsigned n;
		int unsigned src;
		int unsigned dst;
		bit src_bottom;
		bit dst_bottom;
		logic [VAL_W-1:0] card;
		case (f)
			FUNC_RESTART: begin
				n = deck_size_q;
				if (n > MAX_DECK_DEF) n = MAX_DECK_DEF;
				if (n > DEPTH) n = DEPTH;
				for (i = 0; i < n; i++) begin
					deck_mem[0][i] = VAL_W'(i + 1);
					deck_mem[1][i] = VAL_W'(-(i + 1));
				end
				deck_top[0] = 0;
				deck_top[1] = 0;
				deck_cnt[0] = n;
				deck_cnt[1] = n;
				return 1'b1;
			end
			FUNC_MOVE: begin
				src        = cmd[3];
				src_bottom = cmd[2];
				dst        = cmd[1];
				dst_bottom = cmd[0];
				// same end of the same deck: nothing moves
				if (src == dst && src_bottom == dst_bottom) return 1'b0;
				if (deck_cnt[src] == 0) return 1'b0;
				if (src != dst && deck_cnt[dst] >= DEPTH) return 1'b0;
				if (src_bottom) begin
					card = deck_mem[src][(deck_top[src] + deck_cnt[src] - 1) % DEPTH];
				end else begin
					card = deck_mem[src][deck_top[src]];
					deck_top[src] = (deck_top[src] + 1) % DEPTH;
				end
				deck_cnt[src]--;
				if (dst_bottom) begin
					deck_mem[dst][(deck_top[dst] + deck_cnt[dst]) % DEPTH] = card;
				end else begin
					deck_top[dst] = (deck_top[dst] + DEPTH - 1) % DEPTH;
					deck_mem[dst][deck_top[dst]] = card;
				end
				deck_cnt[dst]++;
				return 1'b1;
			end
			FUNC_DUMP: begin
				n = deck_cnt[side];
				if (n == 0) begin
					pending_results.push_back(deck_result_t'{1'b0, VAL_W'(0), 1'b1});
				end else begin
					pending_results.push_back(deck_result_t'{1'b0, VAL_W'(n), 1'b0});
					for (i = 0; i < n; i++)
						pending_results.push_back(deck_result_t'{1'b1,
							deck_mem[side][(deck_top[side] + i) % DEPTH], i == n - 1});
				end
				deck_cnt[side] = 0;
				deck_top[side] = 0;
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	// Mostly small decks, now and then an extreme
	function automatic logic [CFG_W-1:0] pick_deck_size();
		int r;
		r = $urandom_range(9);
		if (r == 0) return '0;
		if (r == 1) return CFG_W'(MAX_DECK_DEF);
		if (r == 2) return CFG_W'($urandom);
		return CFG_W'($urandom_range(8, 1));
	endfunction

	// Offer one request, with random gaps ahead of it, and wait for acceptance
	task automatic send_request(ddcm_func_t f, logic [CMD_W-1:0] cmd, logic side);
		while ($urandom_range(99) < send_idle_pct) begin
			items_if.valid <= 1'b0;
			@(posedge clk);
		end
		items_if.valid     <= 1'b1;
		items_if.func      <= f;
		items_if.command   <= cmd;
		items_if.dump_side <= side;
		@(posedge clk);
		while (!items_if.ready) @(posedge clk);
		if (predict_request(f, cmd, side)) active_count++;
	endtask

	// Stop offering, let every owed result arrive, then let the block settle
	task automatic wait_idle();
		items_if.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_deck_size(logic [CFG_W-1:0] n);
		wait_idle();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= n;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		deck_size_q = n;
	endtask

	// Dumps of empty decks, before and after a restart with no cards
	task automatic test_empty_decks();
		send_request(FUNC_DUMP, '0, SIDE_LEFT);
		set_deck_size('0);
		send_request(FUNC_RESTART, '1, SIDE_RIGHT);
		send_request(FUNC_DUMP, '1, SIDE_RIGHT);
	endtask

	// Largest decks, one deck grown past the restart size
	task automatic test_full_decks();
		set_deck_size(CFG_W'(MAX_DECK_DEF));
		send_request(FUNC_RESTART, '0, SIDE_LEFT);
		send_request(FUNC_MOVE, CMD_RB_TO_LT, SIDE_LEFT);
		send_request(FUNC_DUMP, '0, SIDE_LEFT);
		send_request(FUNC_DUMP, '0, SIDE_RIGHT);
	endtask

	// Every move code on one-card decks, so several hit an empty source
	task automatic test_every_command();
		int c;
		set_deck_size(CFG_W'(1));
		send_request(FUNC_RESTART, '0, SIDE_LEFT);
		for (c = 0; c < 16; c++)
			send_request(FUNC_MOVE, CMD_W'(c), SIDE_LEFT);
		send_request(FUNC_DUMP, '0, SIDE_LEFT);
		send_request(FUNC_DUMP, '0, SIDE_RIGHT);
		send_request(FUNC_NOP, CMD_LT_TO_RB, SIDE_RIGHT);
	endtask

	// Mostly a restart, then a run of moves, one or two dumps, with some stray requests mixed in
	task automatic test_random_traffic(int quota);
		int goal;
		goal = active_count + quota;
		while (active_count < goal) begin
			if ($urandom_range(3) == 0) set_deck_size(pick_deck_size());
			if ($urandom_range(7) != 0)
				send_request(FUNC_RESTART, CMD_W'($urandom), 1'($urandom));
			repeat ($urandom_range(14))
				send_request(FUNC_MOVE, CMD_W'($urandom), 1'($urandom));
			repeat ($urandom_range(2, 1))
				send_request(FUNC_DUMP, CMD_W'($urandom), 1'($urandom));
			if ($urandom_range(4) == 0)
				send_request(ddcm_func_t'($urandom_range(3)), CMD_W'($urandom), 1'($urandom));
		end
	endtask

	// Long receiver hold-off while full decks are dumped back to back
	task automatic test_output_backpressure();
		set_deck_size(CFG_W'(MAX_DECK_DEF));
		send_request(FUNC_RESTART, '0, SIDE_LEFT);
		hold_req = 1'b1;
		send_request(FUNC_DUMP, '0, SIDE_LEFT);
		send_request(FUNC_DUMP, '0, SIDE_RIGHT);
		send_request(FUNC_RESTART, '0, SIDE_LEFT);
		send_request(FUNC_MOVE, CMD_LT_TO_RB, SIDE_LEFT);
		send_request(FUNC_DUMP, '0, SIDE_RIGHT);
		send_request(FUNC_DUMP, '0, SIDE_LEFT);
		wait_idle();
	endtask

	// Receiver ready: random stalls, forced low during a hold-off
	always @(posedge clk)
		results_if.ready <= !hold_on && ($urandom_range(99) >= recv_idle_pct);

	// Hold-off counter
	initial begin
		hold_on = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_on <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_on <= 1'b0;
			end
		end
	end

	// Result checker: each accepted result against the oldest expectation
	always @(posedge clk) begin
		deck_result_t want;
		if (arst_n && results_if.valid && results_if.ready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: is_card %0d value %0d last %0d",
					results_if.is_card, results_if.value, results_if.last);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (results_if.is_card !== want.is_card) begin
					$error("is_card: expected %0d, got %0d", want.is_card, results_if.is_card);
					fail_count++;
				end
				if (results_if.value !== want.value) begin
					$error("value: expected %0d, got %0d", want.value, results_if.value);
					fail_count++;
				end
				if (results_if.last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, results_if.last);
					fail_count++;
				end
			end
		end
	end

	// Run limit
	initial begin
		#(TIMEOUT_NS);
		$display("CHECKS FAILED");
		$finish;
	end

	// Main sequence
	initial begin
		arst_n             = 1'b0;
		cfg_wr_en          = 1'b0;
		cfg_wr_data        = '0;
		items_if.valid     = 1'b0;
		items_if.func      = FUNC_NOP;
		items_if.command   = '0;
		items_if.dump_side = 1'b0;
		results_if.ready   = 1'b0;
		deck_top[0]        = 0;
		deck_top[1]        = 0;
		deck_cnt[0]        = 0;
		deck_cnt[1]        = 0;
		deck_size_q        = '0;
		fail_count         = 0;
		active_count       = 0;
		send_idle_pct      = 38;
		recv_idle_pct      = 68;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_decks();
		test_full_decks();
		test_every_command();
		test_random_traffic(95);

		send_idle_pct = 68;
		recv_idle_pct = 38;
		test_random_traffic(95);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_output_backpressure();
		test_random_traffic(90);

		wait_idle();
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/ddcm_pkg.sv
hw/rtl/ddcm_in_if.sv
hw/rtl/ddcm_out_if.sv
hw/rtl/ddcm_ctrl.sv
hw/rtl/ddcm_dp.sv
hw/rtl/dual_deque_card_mover.sv
tb/tb_top.sv
